### design/suffix_automaton_substring_query_top_macros.svh
// assertion macros shared by the suffix automaton query block
`ifndef SUFFIX_AUTOMATON_SUBSTRING_QUERY_TOP_MACROS_SVH
`define SUFFIX_AUTOMATON_SUBSTRING_QUERY_TOP_MACROS_SVH

// plain property checked on every clock edge out of reset
`define SAQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every clock edge out of reset
`define SAQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/saq_pkg.sv
// package: shared constants and types of the suffix automaton query block
`default_nettype none
package saq_pkg;

  localparam int MAX_STATES_DEF = 8192;
  localparam int ALPHABET_DEF   = 26;
  localparam int SYM_W          = 5;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  // write strobes from the sequencer to the two memories
  typedef struct packed {
    logic row_we;
    logic node_we;
  } mem_ctl_t;

endpackage
`default_nettype wire

### design/saq_if.sv
// interfaces: input symbol channel and result channel
`default_nettype none
interface saq_in_if;
  import saq_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [SYM_W-1:0] symbol;
  logic             first_of_query;
  logic             last_of_query;
  modport source (output valid, action, symbol, first_of_query, last_of_query, input ready);
  modport sink (input valid, action, symbol, first_of_query, last_of_query, output ready);
endinterface

interface saq_out_if;
  logic valid;
  logic ready;
  logic found;
  modport source (output valid, found, input ready);
  modport sink (input valid, found, output ready);
endinterface
`default_nettype wire

### design/saq_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module saq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### design/saq_ctrl.sv
// sequencer: suffix link walk, clone and query walk over the state memories
`default_nettype none
`include "suffix_automaton_substring_query_top_macros.svh"
module saq_ctrl import saq_pkg::*; #(
  parameter int MAX_STATES = MAX_STATES_DEF,
  parameter int ALPHABET   = ALPHABET_DEF,
  localparam int SW = $clog2(MAX_STATES),
  localparam int RW = ALPHABET * SW
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  saq_in_if.sink       in_i,
  saq_out_if.source    out_o,
  output mem_ctl_t     mem_ctl_o,
  output logic [SW-1:0]   raddr_o,
  output logic [SW-1:0]   row_waddr_o,
  output logic [RW-1:0]   row_wdata_o,
  output logic [SW-1:0]   node_waddr_o,
  output logic [2*SW-1:0] node_wdata_o,
  input  wire logic [RW-1:0]   row_rdata_i,
  input  wire logic [2*SW-1:0] node_rdata_i
);

  localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int CW = SW + 2;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_Q_RD = 4'd2;
  localparam logic [3:0] S_Q_EV = 4'd3;
  localparam logic [3:0] S_OUT  = 4'd4;
  localparam logic [3:0] S_A_RD = 4'd5;
  localparam logic [3:0] S_A_EV = 4'd6;
  localparam logic [3:0] S_C_RD = 4'd7;
  localparam logic [3:0] S_C_EV = 4'd8;
  localparam logic [3:0] S_C_Q  = 4'd9;
  localparam logic [3:0] S_R_RD = 4'd10;
  localparam logic [3:0] S_R_EV = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  // transition target zero means absent: the root is never a target
  typedef logic [ALPHABET-1:0][SW-1:0] row_t;

  logic [3:0]  state_q, state_d;
  logic [SW:0] count_q, count_d;
  logic [SW-1:0] last_q, last_d, qs_q, qs_d, p_q, p_d, cur_q, cur_d;
  logic [SW-1:0] tq_q, tq_d, cl_q, cl_d, lenp_q, lenp_d, lenq_q, lenq_d;
  logic [SW-1:0] lencur_q, lencur_d, linkcur_q, linkcur_d;
  logic [AW-1:0] sym_q, sym_d;
  logic dead_q, dead_d, qlast_q, qlast_d, fwalk_q, fwalk_d;
  logic oval_q, oval_d, found_q, found_d;

  row_t row_rd, row_wr;
  logic [SW-1:0] tgt, rd_len, rd_link;
  logic sym_ok, room_ok, slot_free, q_first_dead;
  logic [SW-1:0] q_start;
  logic [AW-1:0] in_sym;

  assign row_rd  = row_t'(row_rdata_i);
  assign tgt     = row_rd[sym_q];
  assign rd_len  = node_rdata_i[2*SW-1:SW];
  assign rd_link = node_rdata_i[SW-1:0];
  assign in_sym  = AW'(in_i.symbol);
  assign sym_ok  = 32'(in_i.symbol) < ALPHABET;
  assign room_ok = (CW'(count_q) + CW'(2)) <= CW'(MAX_STATES);
  assign slot_free = !oval_q || out_o.ready;
  assign q_start = in_i.first_of_query ? '0 : qs_q;
  assign q_first_dead = in_i.first_of_query ? 1'b0 : dead_q;

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = oval_q;
  assign out_o.found = found_q;

  // sequencer next state and memory port control
  always_comb begin
    state_d = state_q;  count_d = count_q;  last_d = last_q;  qs_d = qs_q;
    p_d = p_q;  cur_d = cur_q;  tq_d = tq_q;  cl_d = cl_q;  lenp_d = lenp_q;
    lenq_d = lenq_q;  lencur_d = lencur_q;  linkcur_d = linkcur_q;  sym_d = sym_q;
    dead_d = dead_q;  qlast_d = qlast_q;  fwalk_d = fwalk_q;
    oval_d = oval_q && !out_o.ready;  found_d = found_q;
    mem_ctl_o = '0;
    raddr_o = p_q;
    row_waddr_o = p_q;
    row_wr = row_rd;
    node_waddr_o = cur_q;
    node_wdata_o = {lencur_q, linkcur_q};
    case (state_q)
      S_INIT: begin
        mem_ctl_o.row_we = 1'b1;
        mem_ctl_o.node_we = 1'b1;
        row_waddr_o = '0;
        row_wr = '0;
        node_waddr_o = '0;
        node_wdata_o = '0;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_i.valid) begin
          sym_d = in_sym;
          if (in_i.action == ACT_APPEND) begin
            if (sym_ok && room_ok) begin
              cur_d = count_q[SW-1:0];
              count_d = count_q + 1'b1;
              p_d = last_q;
              fwalk_d = 1'b1;
              state_d = S_A_RD;
            end
          end else begin
            qs_d = q_start;
            qlast_d = in_i.last_of_query;
            if (!q_first_dead && sym_ok) begin
              dead_d = 1'b0;
              state_d = S_Q_RD;
            end else begin
              dead_d = 1'b1;
              if (in_i.last_of_query) state_d = S_OUT;
            end
          end
        end
      end
      S_Q_RD: begin
        raddr_o = qs_q;
        state_d = S_Q_EV;
      end
      S_Q_EV: begin
        if (tgt == '0) dead_d = 1'b1;
        else qs_d = tgt;
        state_d = qlast_q ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (slot_free) begin
          oval_d = 1'b1;
          found_d = !dead_q;
          qs_d = '0;
          dead_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_A_RD: begin
        // the new state's row starts with every transition absent
        if (fwalk_q) begin
          mem_ctl_o.row_we = 1'b1;
          row_waddr_o = cur_q;
          row_wr = '0;
        end
        state_d = S_A_EV;
      end
      S_A_EV: begin
        fwalk_d = 1'b0;
        if (fwalk_q) lencur_d = rd_len + 1'b1;
        if (tgt == '0) begin
          mem_ctl_o.row_we = 1'b1;
          row_wr[sym_q] = cur_q;
          if (p_q == '0) begin
            linkcur_d = '0;
            state_d = S_FIN;
          end else begin
            p_d = rd_link;
            state_d = S_A_RD;
          end
        end else begin
          tq_d = tgt;
          lenp_d = rd_len;
          state_d = S_C_RD;
        end
      end
      S_C_RD: begin
        raddr_o = tq_q;
        state_d = S_C_EV;
      end
      S_C_EV: begin
        if (rd_len == lenp_q + 1'b1) begin
          linkcur_d = tq_q;
          state_d = S_FIN;
        end else begin
          // clone copies the row and link of the target
          cl_d = count_q[SW-1:0];
          count_d = count_q + 1'b1;
          lenq_d = rd_len;
          mem_ctl_o.row_we = 1'b1;
          row_waddr_o = count_q[SW-1:0];
          mem_ctl_o.node_we = 1'b1;
          node_waddr_o = count_q[SW-1:0];
          node_wdata_o = {lenp_q + 1'b1, rd_link};
          state_d = S_C_Q;
        end
      end
      S_C_Q: begin
        mem_ctl_o.node_we = 1'b1;
        node_waddr_o = tq_q;
        node_wdata_o = {lenq_q, cl_q};
        linkcur_d = cl_q;
        state_d = S_R_RD;
      end
      S_R_RD: begin
        state_d = S_R_EV;
      end
      S_R_EV: begin
        if (tgt == tq_q) begin
          mem_ctl_o.row_we = 1'b1;
          row_wr[sym_q] = cl_q;
          if (p_q == '0) state_d = S_FIN;
          else begin
            p_d = rd_link;
            state_d = S_R_RD;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        mem_ctl_o.node_we = 1'b1;
        last_d = cur_q;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    row_wdata_o = RW'(row_wr);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      count_q <= (SW+1)'(1);
      last_q  <= '0;
      qs_q    <= '0;
      dead_q  <= 1'b0;
      oval_q  <= 1'b0;
      fwalk_q <= 1'b0;
      qlast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      last_q  <= last_d;
      qs_q    <= qs_d;
      dead_q  <= dead_d;
      oval_q  <= oval_d;
      fwalk_q <= fwalk_d;
      qlast_q <= qlast_d;
    end
  end

  // walk payload registers
  always_ff @(posedge clk_i) begin
    p_q <= p_d;  cur_q <= cur_d;  tq_q <= tq_d;  cl_q <= cl_d;
    lenp_q <= lenp_d;  lenq_q <= lenq_d;  lencur_q <= lencur_d;
    linkcur_q <= linkcur_d;  sym_q <= sym_d;  found_q <= found_d;
  end

  `SAQ_ASSERT(a_count_bound, count_q <= (SW+1)'(MAX_STATES), "state count overflow")
  `SAQ_ASSERT(a_last_alloc, (SW+1)'(last_q) < count_q, "last state not allocated")
  `SAQ_ASSERT_IMP(a_row_wr_alloc, mem_ctl_o.row_we, (SW+1)'(row_waddr_o) < count_d, "bad row write")
  `SAQ_ASSERT_IMP(a_out_hold, oval_q && !out_o.ready, ##1 oval_q, "result dropped under stall")

endmodule
`default_nettype wire

### design/suffix_automaton_substring_query_top.sv
// Online suffix automaton over a lowercase text with substring queries.
// in_i carries one item per transaction: action 0 appends a symbol to the
// text, action 1 feeds one query pattern symbol (first_of_query restarts at
// the root, last_of_query asks for the answer). out_o carries one transaction
// with found for each query item marked last; appends give no result.
// in_i.ready is high only while the sequencer is idle; one item at a time.
// A query symbol does one registered row read; a symbol marked last then
// loads the result register. An append is accepted, reads each suffix link
// visited, checks the stop target, and when a clone is made relinks the
// target and redirects links until the walk stops; a final step closes it.
// Every step goes through the single read address shared by the row memory
// (all transitions of a state) and the node memory (length and link).
// After reset the init state writes the root's entries, then the block is idle.
// A result waits in the output register while out_o.ready is low; a further
// query answer waits in the sequencer until that register frees.
`default_nettype none
module suffix_automaton_substring_query_top import saq_pkg::*; #(
  parameter int MAX_STATES = MAX_STATES_DEF,
  parameter int ALPHABET   = ALPHABET_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  saq_in_if.sink    in_i,
  saq_out_if.source out_o
);

  localparam int SW = $clog2(MAX_STATES);
  localparam int RW = ALPHABET * SW;

  mem_ctl_t        mem_ctl;
  logic [SW-1:0]   raddr, row_waddr, node_waddr;
  logic [RW-1:0]   row_wdata, row_rdata;
  logic [2*SW-1:0] node_wdata, node_rdata;

  // sequencer
  saq_ctrl #(.MAX_STATES(MAX_STATES), .ALPHABET(ALPHABET)) u_ctrl (
    .clk_i, .rst_ni, .in_i, .out_o,
    .mem_ctl_o(mem_ctl), .raddr_o(raddr),
    .row_waddr_o(row_waddr), .row_wdata_o(row_wdata),
    .node_waddr_o(node_waddr), .node_wdata_o(node_wdata),
    .row_rdata_i(row_rdata), .node_rdata_i(node_rdata)
  );

  // transition rows
  saq_ram #(.W(RW), .D(MAX_STATES)) u_row_ram (
    .clk_i, .we_i(mem_ctl.row_we), .waddr_i(row_waddr), .wdata_i(row_wdata),
    .raddr_i(raddr), .rdata_o(row_rdata)
  );

  // state length and suffix link
  saq_ram #(.W(2*SW), .D(MAX_STATES)) u_node_ram (
    .clk_i, .we_i(mem_ctl.node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .raddr_i(raddr), .rdata_o(node_rdata)
  );

endmodule
`default_nettype wire
